// ===== sv/fps_pkg.sv =====
// Shared constants, codes and control types of the Fenwick prefix-sum table.
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  localparam int unsigned DEPTH   = 4096;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = ADDR_W + 1;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned RIDX_W  = PADDR_W - 2;

  localparam logic [CFG_W-1:0] ACTIVE_SIZE_RST = CFG_W'(4096);

  localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [RIDX_W-1:0] REG_ACTIVE_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_QRY_RD,
    ST_QRY_ACC,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic ld_add;
    logic ld_qry;
    logic add_rd;
    logic add_step;
    logic qry_step;
    logic acc_en;
    logic clr_wr;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic add_ok;
    logic pos_neg;
    logic add_more;
    logic qry_more;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/fps_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/fps_ctrl.sv =====
// Controller state machine that sequences adds, queries and store clearing.
`timescale 1ns / 1ps
`default_nettype none

module fps_ctrl import fps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ACT_W-1:0] action_i,
  output logic             in_ready_o,
  input  stat_t            st_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (st_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (action_i)
            ACT_ADD: begin
              cmd_o.ld_add = 1'b1;
              if (st_i.add_ok) begin
                state_d = ST_ADD_RD;
              end
            end
            ACT_QUERY: begin
              cmd_o.ld_qry = 1'b1;
              state_d = st_i.pos_neg ? ST_RESULT : ST_QRY_RD;
            end
            ACT_CLEAR: begin
              state_d = ST_CLEAR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd_o.add_step = 1'b1;
        if (!st_i.add_more) begin
          state_d = ST_IDLE;
        end
      end
      ST_QRY_RD: begin
        cmd_o.qry_step = 1'b1;
        state_d = ST_QRY_ACC;
      end
      ST_QRY_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (st_i.qry_more) begin
          cmd_o.qry_step = 1'b1;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (st_i.out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Every write of an add is preceded by the read of the same node.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ADD_WR |-> $past(state_q) == ST_ADD_RD || $past(state_q) == ST_ADD_WR)
    else $error("add write phase entered without a read");

  // Accumulation only follows a node read of the same query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_QRY_ACC |-> $past(state_q) == ST_QRY_RD || $past(state_q) == ST_QRY_ACC)
    else $error("query accumulate entered without a read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.ld_add, cmd_o.ld_qry, cmd_o.add_rd, cmd_o.add_step,
              cmd_o.qry_step, cmd_o.clr_wr, cmd_o.ld_out}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== sv/fps_dp.sv =====
// Datapath: node store, index walker, accumulator, clear counter and result register.
`timescale 1ns / 1ps
`default_nettype none

module fps_dp import fps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             st_o,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] delta_i,
  input  logic [CFG_W-1:0]  active_size_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [DATA_W-1:0] prefix_sum_o
);

  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] delta_q;
  logic [DATA_W-1:0] out_q;
  logic              out_valid_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  logic [CMP_W-1:0]  pos_ext, bound, qry_last;
  logic [CNT_W-1:0]  idx_dec, idx_up;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  assign pos_ext  = CMP_W'(position_i[POS_W-2:0]);
  assign bound    = (CMP_W'(active_size_i) < CMP_W'(DEPTH)) ? CMP_W'(active_size_i)
                                                            : CMP_W'(DEPTH);
  assign qry_last = (pos_ext >= CMP_W'(DEPTH)) ? CMP_W'(DEPTH - 1) : pos_ext;

  // Adds climb by setting the lowest clear bit; queries hold index plus one and
  // strip the lowest set bit.
  assign idx_up  = idx_q | (idx_q + 1'b1);
  assign idx_dec = idx_q - 1'b1;

  always_comb begin
    st_o.add_ok   = !position_i[POS_W-1] && (pos_ext < bound);
    st_o.pos_neg  = position_i[POS_W-1];
    st_o.add_more = CMP_W'(idx_up) < bound;
    st_o.qry_more = idx_q != '0;
    st_o.clr_last = clr_cnt_q == ADDR_W'(DEPTH - 1);
    st_o.out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    ram_we    = cmd_i.add_step || cmd_i.clr_wr;
    ram_waddr = cmd_i.clr_wr ? clr_cnt_q : idx_q[ADDR_W-1:0];
    ram_wdata = cmd_i.clr_wr ? '0 : ram_rdata + delta_q;
    ram_re    = cmd_i.add_rd || (cmd_i.add_step && st_o.add_more) || cmd_i.qry_step;
    if (cmd_i.qry_step) begin
      ram_raddr = idx_dec[ADDR_W-1:0];
    end else if (cmd_i.add_step) begin
      ram_raddr = idx_up[ADDR_W-1:0];
    end else begin
      ram_raddr = idx_q[ADDR_W-1:0];
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.ld_add) begin
      idx_d = CNT_W'(pos_ext);
    end else if (cmd_i.ld_qry) begin
      idx_d = CNT_W'(qry_last) + 1'b1;
    end else if (cmd_i.add_step) begin
      idx_d = idx_up;
    end else if (cmd_i.qry_step) begin
      idx_d = idx_dec & idx_q;
    end
    acc_d = acc_q;
    if (cmd_i.ld_qry) begin
      acc_d = '0;
    end else if (cmd_i.acc_en) begin
      acc_d = acc_q + ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= st_o.clr_last ? '0 : clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.ld_add) begin
      delta_q <= delta_i;
    end
    if (cmd_i.ld_out) begin
      out_q <= acc_q;
    end
  end

  fps_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_nodes (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign prefix_sum_o = out_q;

  // A query step always has a node left to read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.qry_step |-> idx_q != '0)
    else $error("query stepped past the root");

  // A result word is only loaded into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_out |-> !out_valid_q || out_ready_i)
    else $error("result overwrote an unread word");

endmodule

`default_nettype wire

// ===== sv/fenwick_prefix_sum_table_core.sv =====
// Top level of the Fenwick prefix-sum table: APB register, controller and datapath.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    action_i, position_i, delta_i
//   out      output     out_valid_o / out_ready_i  prefix_sum_o
//   cfg      APB        psel, penable, pready      paddr, pwdata, prdata
//
// An add reads and rewrites one node per step (at most log2(DEPTH)+1 = 13 nodes), a query
// reads one node per step; an ignored add, an unused action and a query at a negative
// position read no node. The walk visits one node per cycle through the write and read
// ports of the node RAM. A clear writes zero to every node; after reset the store is swept
// to zero the same way before the first word is taken. A waiting result word does not stop
// adds or clears; a second query finishes its walk and then waits.
`timescale 1ns / 1ps
`default_nettype none

module fenwick_prefix_sum_table_core import fps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic signed [POS_W-1:0]  position_i,
  input  logic signed [DATA_W-1:0] delta_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] prefix_sum_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  logic [CFG_W-1:0]  active_size_q;
  logic [RIDX_W-1:0] reg_idx;
  cmd_t              cmd;
  stat_t             st;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_size_q <= ACTIVE_SIZE_RST;
    end else if (psel && penable && pwrite && (reg_idx == REG_ACTIVE_SIZE)) begin
      active_size_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_SIZE: prdata = PDATA_W'(active_size_q);
      default:         prdata = '0;
    endcase
  end

  fps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fps_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .position_i    (position_i),
    .delta_i       (delta_i),
    .active_size_i (active_size_q),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .prefix_sum_o  (prefix_sum_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Fenwick prefix-sum table core.
`timescale 1ns / 1ps

module tb_top;
  import fps_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  // A clear sweeps every node, so this covers the longest word the block can be busy with.
  localparam int SETTLE_CYCLES = DEPTH + 100;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 120;

  class prefix_sum_board;
    logic [DATA_W-1:0] nodes [DEPTH];
    logic [CFG_W-1:0]  size_reg;
    logic [DATA_W-1:0] sums_due [$];
    int                faults;

    function new();
      wipe();
      size_reg = ACTIVE_SIZE_RST;
      faults = 0;
    endfunction

    function void wipe();
      foreach (nodes[i]) nodes[i] = '0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      faults++;
    endtask

    function void note_word(logic [ACT_W-1:0] act, logic signed [POS_W-1:0] pos,
                            logic [DATA_W-1:0] dlt);
      int idx;
      int limit;
      logic [DATA_W-1:0] acc;
      idx = int'(pos);
      limit = (size_reg > DEPTH) ? DEPTH : int'(size_reg);
      case (act)
        ACT_ADD: begin
          if (idx >= 0) begin
            while (idx < limit) begin
              nodes[idx] += dlt;
              idx = idx | (idx + 1);
            end
          end
        end
        ACT_QUERY: begin
          acc = '0;
          while (idx >= 0) begin
            acc += nodes[idx];
            idx = (idx & (idx + 1)) - 1;
          end
          sums_due.push_back(acc);
        end
        ACT_CLEAR: wipe();
        default: ;
      endcase
    endfunction

    task check_sum(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (sums_due.size() == 0) begin
        report($sformatf("result word 0x%08h with no query pending", got));
      end else begin
        want = sums_due.pop_front();
        if (got !== want)
          report($sformatf("prefix_sum 0x%08h, predicted 0x%08h", got, want));
      end
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [ACT_W-1:0]         action_i = ACT_ADD;
  logic signed [POS_W-1:0]  position_i = '0;
  logic signed [DATA_W-1:0] delta_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [DATA_W-1:0] prefix_sum_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  prefix_sum_board board = new();
  bit quiet = 1'b0;
  int stall_left = 0;

  fenwick_prefix_sum_table_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .delta_i      (delta_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .prefix_sum_o (prefix_sum_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  // The receiver stalls in bursts; once the run goes quiet it starts no new stall.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14);
    end
    out_ready_i <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_sum(prefix_sum_o);
  end

  task automatic send_word(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                           logic [DATA_W-1:0] dlt);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    delta_i    <= dlt;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(act, pos, dlt);
    @(negedge clk_i);
  endtask

  task automatic apb_transfer(logic wr, logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({REG_ACTIVE_SIZE, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_active_size(logic [CFG_W-1:0] v);
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b1, PDATA_W'(v), rd);
    board.size_reg = v;
    apb_transfer(1'b0, '0, rd);
    if (rd[CFG_W-1:0] !== v)
      board.report($sformatf("active_size reads 0x%04h, written 0x%04h", rd[CFG_W-1:0], v));
  endtask

  // Waits for every pending sum, then long enough for a trailing clear to finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.sums_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [POS_W-1:0] pick_position(int limit);
    int r;
    int p;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      p = -int'($urandom_range(1, DEPTH));
    end else if (r < 18) begin
      case ($urandom_range(0, 4))
        0: p = 0;
        1: p = DEPTH - 1;
        2: p = limit - 1;
        3: p = limit;
        default: p = limit + 1;
      endcase
    end else if (r < 40) begin
      p = limit + int'($urandom_range(0, 16)) - 8;
    end else begin
      p = $urandom_range(0, DEPTH - 1);
    end
    if (p > DEPTH - 1) p = DEPTH - 1;
    return POS_W'(p);
  endfunction

  function automatic logic [DATA_W-1:0] pick_delta();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '1;
      3: return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 48) return ACT_ADD;
    if (r < 93) return ACT_QUERY;
    if (r < 95) return ACT_CLEAR;
    return ACT_UNUSED;
  endfunction

  initial begin
    logic [CFG_W-1:0] sizes [PHASES];
    int limit;
    sizes = '{13'd0, 13'd1, 13'h1FFF, 13'd4095, 13'd100, 13'd2048, 13'd0, 13'd4096};
    sizes[6] = CFG_W'($urandom_range(2, DEPTH));

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_active_size(CFG_W'(DEPTH));

    // Extremes of every field, the ignored cases and a clear in the middle.
    send_word(ACT_QUERY, 13'h1FFF, 32'h0);
    send_word(ACT_ADD, 13'd0, 32'h7FFF_FFFF);
    send_word(ACT_ADD, 13'd4095, 32'h8000_0000);
    send_word(ACT_ADD, 13'h1FFF, 32'd5);
    send_word(ACT_ADD, 13'h1000, 32'hFFFF_FFFF);
    send_word(ACT_QUERY, 13'd0, 32'hFFFF_FFFF);
    send_word(ACT_QUERY, 13'd4095, 32'h0);
    send_word(ACT_QUERY, 13'h1000, 32'h0);
    send_word(ACT_ADD, 13'd0, 32'd1);
    send_word(ACT_QUERY, 13'd4095, 32'h0);
    send_word(ACT_UNUSED, 13'd0, 32'd123);
    send_word(ACT_QUERY, 13'd2047, 32'h0);
    send_word(ACT_CLEAR, 13'd4095, 32'hFFFF_FFFF);
    send_word(ACT_QUERY, 13'd4095, 32'h0);
    send_word(ACT_ADD, 13'h0AAA, 32'hAAAA_AAAA);
    send_word(ACT_ADD, 13'h0555, 32'h5555_5555);
    send_word(ACT_ADD, 13'd2047, 32'hFFFF_FFFF);
    send_word(ACT_QUERY, 13'd4094, 32'h0);
    send_word(ACT_QUERY, 13'h0AAA, 32'h0);
    send_word(ACT_ADD, 13'd4095, 32'hFFFF_FFFF);
    send_word(ACT_QUERY, 13'd4095, 32'h0);
    send_word(ACT_UNUSED, 13'h1FFF, 32'hFFFF_FFFF);

    // Each phase runs under its own bound; nodes left from earlier phases stay visible.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      set_active_size(sizes[ph]);
      limit = (sizes[ph] > DEPTH) ? DEPTH : int'(sizes[ph]);
      if (ph == PHASES - 1) quiet = 1'b1;
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        send_word(pick_action(), pick_position(limit), pick_delta());
    end

    settle();
    if (board.faults == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fps_pkg.sv
sv/fps_ram.sv
sv/fps_ctrl.sv
sv/fps_dp.sv
sv/fenwick_prefix_sum_table_core.sv
tb/tb_top.sv
